// ===== src/accumulator_vm_execute_macros.svh =====
// Assertion macros shared by the accumulator machine RTL.
`ifndef ACCUMULATOR_VM_EXECUTE_MACROS_SVH
`define ACCUMULATOR_VM_EXECUTE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define AVM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Check that a condition is followed by another in the next cycle.
`define AVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define AVM_ASSERT(label, clk, rst_n, prop)
`define AVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/avm_pkg.sv =====
// Types and opcode constants of the accumulator machine execute block.
package avm_pkg;

  localparam logic [4:0] OP_HLT  = 5'd0;
  localparam logic [4:0] OP_IN   = 5'd1;
  localparam logic [4:0] OP_OUT  = 5'd2;
  localparam logic [4:0] OP_LDA  = 5'd3;
  localparam logic [4:0] OP_STA  = 5'd4;
  localparam logic [4:0] OP_ADD  = 5'd5;
  localparam logic [4:0] OP_SUB  = 5'd6;
  localparam logic [4:0] OP_INC  = 5'd7;
  localparam logic [4:0] OP_DEC  = 5'd8;
  localparam logic [4:0] OP_JMP  = 5'd9;
  localparam logic [4:0] OP_JZ   = 5'd10;
  localparam logic [4:0] OP_JN   = 5'd11;
  localparam logic [4:0] OP_LIT  = 5'd12;
  localparam logic [4:0] OP_CAL  = 5'd13;
  localparam logic [4:0] OP_RET  = 5'd14;
  localparam logic [4:0] OP_LPA  = 5'd15;
  localparam logic [4:0] OP_SPA  = 5'd16;
  localparam logic [4:0] OP_ASR  = 5'd17;
  localparam logic [4:0] OP_NOP  = 5'd18;
  localparam logic [4:0] OP_PUSH = 5'd19;
  localparam logic [4:0] OP_POP  = 5'd20;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [15:0] operand;
    logic signed [15:0] in_value;
  } avm_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic signed [15:0] acc_value;
    logic               out_valid;
    logic signed [15:0] out_value;
    logic               halted;
  } avm_out_t;

endpackage

// ===== src/accumulator_vm_execute.sv =====
// Accumulator machine execute block: one instruction per input transaction.
//
// Each input transaction carries one instruction (opcode, operand, IN value);
// each yields exactly one result transaction with the next pc, the
// accumulator, the OUT strobe and value, and the halted flag. An input
// register takes the next transaction while the current one executes, and an
// output register holds a result until it is taken. HLT, IN, OUT, jumps,
// LIT, CAL, ASR and NOP finish straight from idle; RET reads the return stack
// (S_RSRD). Every other instruction reduces its address modulo MEM_DEPTH
// (reciprocal multiply in S_AMUL, correction in S_AFIX): STA writes the cell;
// LDA, ADD and SUB read it and INC and DEC update it (S_RD1); SPA, PUSH, LPA
// and POP read a pointer cell (S_RD1), reduce its value as a second address,
// then SPA and PUSH write that cell, LPA and POP read it (S_RD2). After
// reset a clearing pass writes zeros to both memories; no transaction is
// accepted into execution until it ends. After HLT every instruction changes
// nothing and reports the held pc and accumulator.
`include "accumulator_vm_execute_macros.svh"

module accumulator_vm_execute #(
  parameter int MEM_DEPTH   = 1024,
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  avm_pkg::avm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output avm_pkg::avm_out_t out_data
);
  import avm_pkg::*;

  // Memory geometry and the constants of the address reduction.
  localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CLR_N = (MEM_DEPTH > STACK_DEPTH) ? MEM_DEPTH : STACK_DEPTH;
  localparam int CW    = $clog2(CLR_N);
  localparam longint unsigned RECIP = 64'h1_0000_0000 / MEM_DEPTH;
  localparam logic [28:0] RECIP_C = 29'(RECIP);
  localparam logic [17:0] DEPTH_C = 18'(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_AMUL, S_AFIX, S_RD1, S_RD2, S_RSRD
  } state_t;

  // Control state.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  logic            buf_full_r, buf_full_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [15:0]     pc_r, pc_nxt;
  logic            halt_r, halt_nxt;
  logic [SW-1:0]   sp_r, sp_nxt;
  logic            ind_r, ind_nxt;

  // Payload registers.
  avm_in_t         buf_r;
  avm_out_t        out_r, out_nxt;
  logic [4:0]      op_r, op_nxt;
  logic [15:0]     w_r, w_nxt;
  logic [12:0]     q_r, q_nxt;
  logic [AW-1:0]   p_r, p_nxt;

  // Memory ports.
  logic [15:0]     dm_mem [MEM_DEPTH];
  logic            dm_we, dm_re;
  logic [AW-1:0]   dm_wa, dm_ra;
  logic [15:0]     dm_wd, dm_rdata_r;
  logic [15:0]     rs_mem [STACK_DEPTH];
  logic            rs_we, rs_re;
  logic [SW-1:0]   rs_wa, rs_ra;
  logic [15:0]     rs_wd, rs_rdata_r;

  // Sequencer handshake terms.
  logic            take, fin, out_free, commit, accept_in;
  logic [15:0]     fin_acc, fin_pc, fin_oval;
  logic            fin_ov, fin_halt;

  // Address reduction datapath.
  logic [44:0]     prod;
  logic [29:0]     qd;
  logic [17:0]     r0, r1;
  logic [AW-1:0]   addr_fix;

  logic [15:0]     pc_plus2;
  logic [SW-1:0]   sp_inc, sp_dec;
  logic [3:0]      sh;
  logic            clr_dm, clr_rs;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !buf_full_r || take;
  assign accept_in = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pc_plus2 = pc_r + 16'd2;
  assign sp_inc   = (sp_r == SW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec   = (sp_r == '0) ? SW'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign sh       = (|buf_r.operand[15:4]) ? 4'd15 : buf_r.operand[3:0];

  // Word modulo MEM_DEPTH: the quotient estimate is low by at most one.
  assign prod     = 45'(w_r) * 45'(RECIP_C);
  assign qd       = 30'(q_r) * 30'(DEPTH_C);
  assign r0       = {2'b00, w_r} - qd[17:0];
  assign r1       = (r0 >= DEPTH_C) ? r0 - DEPTH_C : r0;
  assign addr_fix = r1[AW-1:0];

  assign clr_dm = ({1'b0, clr_r} < (CW + 1)'(MEM_DEPTH));
  assign clr_rs = ({1'b0, clr_r} < (CW + 1)'(STACK_DEPTH));

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    acc_nxt      = acc_r;
    pc_nxt       = pc_r;
    halt_nxt     = halt_r;
    sp_nxt       = sp_r;
    ind_nxt      = ind_r;
    op_nxt       = op_r;
    w_nxt        = w_r;
    q_nxt        = q_r;
    p_nxt        = p_r;
    take         = 1'b0;
    fin          = 1'b0;
    fin_acc      = acc_r;
    fin_pc       = pc_plus2;
    fin_ov       = 1'b0;
    fin_oval     = '0;
    fin_halt     = halt_r;
    dm_we        = 1'b0;
    dm_wa        = p_r;
    dm_wd        = acc_r;
    dm_re        = 1'b0;
    dm_ra        = addr_fix;
    rs_we        = 1'b0;
    rs_wa        = sp_r;
    rs_wd        = pc_r;
    rs_re        = 1'b0;
    rs_ra        = sp_dec;

    case (state_r)
      S_CLEAR: begin
        // Zero both memories, one entry per cycle.
        dm_we   = clr_dm;
        dm_wa   = clr_r[AW-1:0];
        dm_wd   = '0;
        rs_we   = clr_rs;
        rs_wa   = clr_r[SW-1:0];
        rs_wd   = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (buf_full_r) begin
          if (halt_r) begin
            fin    = 1'b1;
            fin_pc = pc_r;
          end else begin
            case (buf_r.opcode)
              OP_HLT: begin
                fin      = 1'b1;
                fin_pc   = pc_r;
                fin_halt = 1'b1;
              end
              OP_IN: begin
                fin     = 1'b1;
                fin_acc = buf_r.in_value;
              end
              OP_OUT: begin
                fin      = 1'b1;
                fin_ov   = 1'b1;
                fin_oval = acc_r;
              end
              OP_JMP: begin
                fin    = 1'b1;
                fin_pc = buf_r.operand;
              end
              OP_JZ: begin
                fin = 1'b1;
                if (acc_r == '0) begin
                  fin_pc = buf_r.operand;
                end
              end
              OP_JN: begin
                fin = 1'b1;
                if (acc_r[15]) begin
                  fin_pc = buf_r.operand;
                end
              end
              OP_LIT: begin
                fin     = 1'b1;
                fin_acc = buf_r.operand;
              end
              OP_ASR: begin
                fin     = 1'b1;
                fin_acc = 16'($signed(acc_r) >>> sh);
              end
              OP_CAL: begin
                // Push the pc; commit the write and pointer with the result.
                fin    = 1'b1;
                fin_pc = buf_r.operand;
                rs_we  = out_free;
                if (out_free) begin
                  sp_nxt = sp_inc;
                end
              end
              OP_RET: begin
                take      = 1'b1;
                sp_nxt    = sp_dec;
                rs_re     = 1'b1;
                state_nxt = S_RSRD;
              end
              OP_LDA, OP_STA, OP_ADD, OP_SUB, OP_INC, OP_DEC,
              OP_LPA, OP_SPA, OP_PUSH, OP_POP: begin
                take      = 1'b1;
                op_nxt    = buf_r.opcode;
                w_nxt     = buf_r.operand;
                ind_nxt   = 1'b0;
                state_nxt = S_AMUL;
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
      end
      S_AMUL: begin
        q_nxt     = prod[44:32];
        state_nxt = S_AFIX;
      end
      S_AFIX: begin
        if (!ind_r) begin
          p_nxt = addr_fix;
          if (op_r == OP_STA) begin
            fin   = 1'b1;
            dm_we = out_free;
            dm_wa = addr_fix;
          end else begin
            dm_re     = 1'b1;
            state_nxt = S_RD1;
          end
        end else if (op_r == OP_SPA || op_r == OP_PUSH) begin
          fin   = 1'b1;
          dm_we = out_free;
          dm_wa = addr_fix;
        end else begin
          dm_re     = 1'b1;
          state_nxt = S_RD2;
        end
      end
      S_RD1: begin
        case (op_r)
          OP_LDA: begin
            fin     = 1'b1;
            fin_acc = dm_rdata_r;
          end
          OP_ADD: begin
            fin     = 1'b1;
            fin_acc = acc_r + dm_rdata_r;
          end
          OP_SUB: begin
            fin     = 1'b1;
            fin_acc = acc_r - dm_rdata_r;
          end
          OP_INC: begin
            fin   = 1'b1;
            dm_we = out_free;
            dm_wd = dm_rdata_r + 16'd1;
          end
          OP_DEC: begin
            fin   = 1'b1;
            dm_we = out_free;
            dm_wd = dm_rdata_r - 16'd1;
          end
          OP_PUSH: begin
            // Bump the pointer cell now; the pushed value lands next pass.
            dm_we     = 1'b1;
            dm_wd     = dm_rdata_r + 16'd1;
            w_nxt     = dm_rdata_r + 16'd1;
            ind_nxt   = 1'b1;
            state_nxt = S_AMUL;
          end
          OP_LPA, OP_SPA, OP_POP: begin
            w_nxt     = dm_rdata_r;
            ind_nxt   = 1'b1;
            state_nxt = S_AMUL;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_RD2: begin
        fin     = 1'b1;
        fin_acc = dm_rdata_r;
        if (op_r == OP_POP) begin
          // Decrement the pointer cell from the value read in the first pass.
          dm_we = out_free;
          dm_wd = w_r - 16'd1;
        end
      end
      S_RSRD: begin
        fin    = 1'b1;
        fin_pc = rs_rdata_r + 16'd2;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Retire into the output register when it is free; otherwise hold.
    commit = fin && out_free;
    if (commit) begin
      acc_nxt   = fin_acc;
      pc_nxt    = fin_pc;
      halt_nxt  = fin_halt;
      state_nxt = S_IDLE;
      if (state_r == S_IDLE) begin
        take = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end

    buf_full_nxt = buf_full_r;
    if (take) begin
      buf_full_nxt = 1'b0;
    end
    if (accept_in) begin
      buf_full_nxt = 1'b1;
    end

    out_nxt.next_pc   = fin_pc;
    out_nxt.acc_value = fin_acc;
    out_nxt.out_valid = fin_ov;
    out_nxt.out_value = fin_oval;
    out_nxt.halted    = fin_halt;
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      buf_full_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      sp_r        <= '0;
      ind_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      buf_full_r  <= buf_full_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      sp_r        <= sp_nxt;
      ind_r       <= ind_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      buf_r <= in_data;
    end
    if (commit) begin
      out_r <= out_nxt;
    end
    op_r <= op_nxt;
    w_r  <= w_nxt;
    q_r  <= q_nxt;
    p_r  <= p_nxt;
  end

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (dm_re) begin
      dm_rdata_r <= dm_mem[dm_ra];
    end
  end

  // Return stack memory.
  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_wd;
    end
    if (rs_re) begin
      rs_rdata_r <= rs_mem[rs_ra];
    end
  end

  // The sequencer never reads and writes the same data word in one cycle.
  `AVM_ASSERT(a_no_rw_overlap, clk, rst_n, !(dm_we && dm_re && (dm_wa == dm_ra)))
  // No instruction retires during the clearing pass.
  `AVM_ASSERT(a_no_commit_in_clear, clk, rst_n, !((state_r == S_CLEAR) && commit))
  // A held result is never overwritten.
  `AVM_ASSERT(a_commit_slot_free, clk, rst_n, !commit || !out_valid_r || out_ready)
  // Once halted, stay halted.
  `AVM_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_r, halt_r)

endmodule

// ===== tb/tb_accumulator_vm_execute.sv =====
// Self-checking testbench for the accumulator machine execute block.
module tb_accumulator_vm_execute;
  import avm_pkg::*;

  localparam int MEM_WORDS    = 1024;
  localparam int STACK_WORDS  = 16;
  localparam int CLK_HALF     = 10;
  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_ITEMS   = 100;   // random tail with no idling on either side
  localparam int HALT_TAIL    = 40;    // instructions sent after the machine halts
  localparam int LONG_HOLD    = 300;   // one long receiver stall, in cycles
  localparam int HOLD_AFTER   = 150;   // results taken before the long stall starts
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 4000;  // covers the memory clearing pass after reset

  localparam logic [4:0] OP_SPARE_LO = 5'd21;
  localparam logic [4:0] OP_SPARE_HI = 5'd31;

  localparam logic FROM_MODEL = 1'b0;  // expectation comes from the shadow machine
  localparam logic HAND_TYPED = 1'b1;  // expectation is written into the table

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  avm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  avm_out_t out_data;

  accumulator_vm_execute #(
    .MEM_DEPTH  (MEM_WORDS),
    .STACK_DEPTH(STACK_WORDS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // One row of the directed program: the instruction and, where it is obvious,
  // the result written out by hand.
  typedef struct packed {
    avm_in_t  instr;
    logic     typed;
    avm_out_t want;
  } program_row_t;

  program_row_t directed_program[$];

  // Shadow copy of the machine state.
  logic [15:0] acc_q;
  logic [15:0] pc_q;
  logic [15:0] data_mem [MEM_WORDS];
  logic [15:0] ret_stack [STACK_WORDS];
  logic [3:0]  sp_q;        // STACK_WORDS is 16, so four bits wrap on their own
  logic        halted_q;

  avm_out_t    results_due[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  logic        idle_on;     // random gaps on both channels while set

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Execute one instruction on the shadow machine and return its result.
  function automatic avm_out_t execute_instr(avm_in_t ins);
    avm_out_t           res;
    logic [15:0]        opnd;
    logic [15:0]        next;
    logic [15:0]        ptr;
    logic [9:0]         slot;
    logic signed [15:0] shifted;
    logic [3:0]         count;
    res  = '0;
    opnd = ins.operand;
    next = pc_q + 16'd2;
    slot = opnd[9:0];       // address modulo the memory depth
    if (!halted_q) begin
      case (ins.opcode)
        OP_HLT: begin
          halted_q = 1'b1;
          next     = pc_q;
        end
        OP_IN:  acc_q = ins.in_value;
        OP_OUT: begin
          res.out_valid = 1'b1;
          res.out_value = acc_q;
        end
        OP_LDA: acc_q = data_mem[slot];
        OP_STA: data_mem[slot] = acc_q;
        OP_ADD: acc_q = acc_q + data_mem[slot];
        OP_SUB: acc_q = acc_q - data_mem[slot];
        OP_INC: data_mem[slot] = data_mem[slot] + 16'd1;
        OP_DEC: data_mem[slot] = data_mem[slot] - 16'd1;
        OP_JMP: next = opnd;
        OP_JZ:  if (acc_q == 16'd0) next = opnd;
        OP_JN:  if (acc_q[15]) next = opnd;
        OP_LIT: acc_q = opnd;
        OP_CAL: begin
          ret_stack[sp_q] = pc_q;
          sp_q            = sp_q + 4'd1;
          next            = opnd;
        end
        OP_RET: begin
          sp_q = sp_q - 4'd1;
          next = ret_stack[sp_q] + 16'd2;
        end
        OP_LPA: begin
          ptr   = data_mem[slot];
          acc_q = data_mem[ptr[9:0]];
        end
        OP_SPA: begin
          ptr                 = data_mem[slot];
          data_mem[ptr[9:0]] = acc_q;
        end
        OP_ASR: begin
          // Counts above 15, negative operands among them, saturate.
          count   = (opnd > 16'd15) ? 4'd15 : opnd[3:0];
          shifted = acc_q;
          acc_q   = shifted >>> count;
        end
        OP_PUSH: begin
          data_mem[slot]      = data_mem[slot] + 16'd1;
          ptr                 = data_mem[slot];
          data_mem[ptr[9:0]] = acc_q;
        end
        OP_POP: begin
          ptr            = data_mem[slot];
          acc_q          = data_mem[ptr[9:0]];
          data_mem[slot] = data_mem[slot] - 16'd1;
        end
        default: ;          // NOP and the unused opcodes
      endcase
      pc_q = next;
    end
    res.next_pc   = pc_q;
    res.acc_value = acc_q;
    res.halted    = halted_q;
    return res;
  endfunction

  // Draw one instruction. Addresses mostly hit a small pool of cells (with
  // random high bits that the modulo drops), and literals and IN values are
  // often small, so pointer cells point back into the pool.
  function automatic avm_in_t random_instr(logic allow_halt);
    avm_in_t     ins;
    logic [31:0] r;
    r = $urandom;
    if (allow_halt && $urandom_range(0, 9) == 0) ins.opcode = OP_HLT;
    else if ($urandom_range(0, 99) < 8) ins.opcode = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else ins.opcode = 5'($urandom_range(OP_IN, OP_POP));
    case (ins.opcode)
      OP_LIT:                       ins.operand = ($urandom_range(0, 9) < 7) ?
                                                  {12'd0, r[3:0]} : r[15:0];
      OP_ASR:                       ins.operand = ($urandom_range(0, 9) < 6) ?
                                                  {11'd0, r[4:0]} : r[15:0];
      OP_JMP, OP_JZ, OP_JN, OP_CAL: ins.operand = r[15:0];
      default:                      ins.operand = ($urandom_range(0, 3) != 0) ?
                                                  {r[31:26], 6'd0, r[3:0]} : r[15:0];
    endcase
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       ins.in_value = '0;
      1, 2:    ins.in_value = {12'd0, r[3:0]};
      default: ins.in_value = r[15:0];
    endcase
    return ins;
  endfunction

  function automatic void add_row(logic [4:0] op, logic [15:0] opnd, logic [15:0] inval,
                                  logic typed, logic [15:0] pc, logic [15:0] acc,
                                  logic ov, logic [15:0] oval);
    program_row_t row;
    row.instr.opcode    = op;
    row.instr.operand   = opnd;
    row.instr.in_value  = inval;
    row.typed           = typed;
    row.want.next_pc    = pc;
    row.want.acc_value  = acc;
    row.want.out_valid  = ov;
    row.want.out_value  = oval;
    row.want.halted     = 1'b0;
    directed_program.push_back(row);
  endfunction

  // Offer one instruction, hold it until accepted, then log what it should give.
  task automatic issue_instr(input avm_in_t ins, input logic typed, input avm_out_t want);
    avm_out_t got;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ins;
    do @(posedge clk); while (!(rst_n && in_ready === 1'b1));
    got = execute_instr(ins);
    results_due.push_back(typed ? want : got);
  endtask

  // Stop offering and wait for every pending result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%04h, got 0x%04h", field, want, got);
      mismatches++;
    end
  endtask

  // Stimulus: reset, directed program, random programs, then halt.
  initial begin : stimulus
    avm_out_t none;
    avm_in_t  halt_instr;
    none        = '0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    idle_on     = 1'b1;
    mismatches  = 0;
    acc_q       = '0;
    pc_q        = '0;
    sp_q        = '0;
    halted_q    = 1'b0;
    for (int i = 0; i < MEM_WORDS; i++) data_mem[i] = '0;
    for (int i = 0; i < STACK_WORDS; i++) ret_stack[i] = '0;

    // Directed program, starting from the reset state. Hand-typed rows give
    // next_pc and acc; OUT rows give the strobe and value too.
    add_row(OP_OUT,  16'h0000, 16'h0000, HAND_TYPED, 16'h0002, 16'h0000, 1'b1, 16'h0000);
    add_row(OP_IN,   16'h0000, 16'h8000, HAND_TYPED, 16'h0004, 16'h8000, 1'b0, 16'h0000);
    add_row(OP_OUT,  16'hFFFF, 16'h7FFF, HAND_TYPED, 16'h0006, 16'h8000, 1'b1, 16'h8000);
    // negative count saturates to 15: most negative value smears to all ones
    add_row(OP_ASR,  16'hFFFF, 16'h0000, HAND_TYPED, 16'h0008, 16'hFFFF, 1'b0, 16'h0000);
    add_row(OP_JN,   16'hFFFE, 16'h0000, HAND_TYPED, 16'hFFFE, 16'hFFFF, 1'b0, 16'h0000);
    // pc + 2 wraps to zero
    add_row(OP_IN,   16'h1234, 16'h7FFF, HAND_TYPED, 16'h0000, 16'h7FFF, 1'b0, 16'h0000);
    // all-ones address lands on the top cell
    add_row(OP_STA,  16'hFFFF, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_LIT,  16'h0000, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_LDA,  16'h03FF, 16'h0000, HAND_TYPED, 16'h0006, 16'h7FFF, 1'b0, 16'h0000);
    add_row(OP_INC,  16'h03FF, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_ADD,  16'hFBFF, 16'h0000, HAND_TYPED, 16'h000A, 16'hFFFF, 1'b0, 16'h0000);
    add_row(OP_SUB,  16'h03FF, 16'h0000, HAND_TYPED, 16'h000C, 16'h7FFF, 1'b0, 16'h0000);
    add_row(OP_DEC,  16'h07FF, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_LIT,  16'h0000, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_JZ,   16'd100,  16'h0000, HAND_TYPED, 16'd100,  16'h0000, 1'b0, 16'h0000);
    add_row(OP_JN,   16'd200,  16'h0000, HAND_TYPED, 16'd102,  16'h0000, 1'b0, 16'h0000);
    add_row(OP_CAL,  16'd500,  16'h0000, HAND_TYPED, 16'd500,  16'h0000, 1'b0, 16'h0000);
    add_row(OP_RET,  16'h1111, 16'h0000, HAND_TYPED, 16'd104,  16'h0000, 1'b0, 16'h0000);
    // stack underflow: pointer wraps to the last entry, still zero
    add_row(OP_RET,  16'h0000, 16'h0000, HAND_TYPED, 16'd2,    16'h0000, 1'b0, 16'h0000);
    add_row(OP_LIT,  16'h0005, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_STA,  16'h040A, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_LIT,  16'hFFF9, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_SPA,  16'h000A, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_NOP,  16'hFFFF, 16'hFFFF, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_LPA,  16'hFC0A, 16'h0000, HAND_TYPED, 16'h000E, 16'hFFF9, 1'b0, 16'h0000);
    add_row(OP_PUSH, 16'h000A, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_POP,  16'h000A, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    add_row(OP_JMP,  16'h8000, 16'h0000, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    // unused opcode acts as NOP
    add_row(OP_SPARE_HI, 16'h5555, 16'hAAAA, FROM_MODEL, 16'h0000, 16'h0000, 1'b0, 16'h0000);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_program[i])
      issue_instr(directed_program[i].instr, directed_program[i].typed, directed_program[i].want);
    wait_drained();

    // Random programs. Alternate stretches with and without idling; drop
    // idling entirely near the end. Pause once midway until drained.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n < RANDOM_ITEMS - CALM_ITEMS) && ((n / 90) % 3 != 2);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      issue_instr(random_instr(1'b0), FROM_MODEL, none);
    end

    // Halt, then check that nothing moves afterwards.
    halt_instr.opcode   = OP_HLT;
    halt_instr.operand  = 16'($urandom);
    halt_instr.in_value = 16'($urandom);
    issue_instr(halt_instr, FROM_MODEL, none);
    for (int n = 0; n < HALT_TAIL; n++) issue_instr(random_instr(1'b1), FROM_MODEL, none);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold so the block backs up
  // and stops taking instructions.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned taken;
    logic        long_hold_done;
    stall_left     = 0;
    taken          = 0;
    long_hold_done = 1'b0;
    out_ready     <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) taken++;
      if (stall_left != 0) stall_left--;
      else if (!long_hold_done && taken >= HOLD_AFTER) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      out_ready <= (stall_left == 0);
    end
  end

  // Compare each result transaction against the oldest pending expectation.
  always @(posedge clk) begin : result_check
    avm_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with no instruction pending: next_pc 0x%04h", out_data.next_pc);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        compare_field("next_pc",   want.next_pc,           out_data.next_pc);
        compare_field("acc_value", want.acc_value,         out_data.acc_value);
        compare_field("out_valid", {15'd0, want.out_valid}, {15'd0, out_data.out_valid});
        compare_field("out_value", want.out_value,         out_data.out_value);
        compare_field("halted",    {15'd0, want.halted},   {15'd0, out_data.halted});
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial quiet_cycles = 0;

endmodule
